FILE: design/huffman_code_table_builder_assert.svh
// Assertion macros for the Huffman code table builder.
`ifndef HUFFMAN_CODE_TABLE_BUILDER_ASSERT_SVH
`define HUFFMAN_CODE_TABLE_BUILDER_ASSERT_SVH
`define HCTB_ASSERT_IMPL(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("huffman code table builder check failed");
`define HCTB_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("huffman code table builder check failed");
`endif

FILE: design/hctb_pkg.sv
package hctb_pkg;
	typedef struct packed {
		logic [23:0] symbol_rgb;
		logic [23:0] symbol_weight;
		logic        last_symbol;
	} hctb_in_t;

	typedef struct packed {
		logic [23:0] leaf_symbol;
		logic [62:0] code_bits;
		logic [5:0]  code_length;
		logic        table_full;
		logic        final_code;
	} hctb_out_t;

	localparam int WEIGHT_W = 31;
	localparam int CODE_W = 63;
	localparam int LEN_W = 6;
endpackage

FILE: design/huffman_code_table_builder.sv
// Load: one cycle per symbol request; the build starts on the request marked last.
// Build: heapify, merges and tree walk run as one sequential state machine with
// registered memory reads; the walk emits codes one at a time and waits while
// the output stalls. Input stalls meanwhile.
// Reset (arst_n low) clears all control state; memories are not cleared.
module huffman_code_table_builder
	import hctb_pkg::*;
#(
	parameter int MAX_SYMBOLS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  hctb_in_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output hctb_out_t out_data
);
	localparam int NODES = 2 * MAX_SYMBOLS - 1;
	localparam int NW = $clog2(NODES);
	localparam int SW = $clog2(MAX_SYMBOLS);
	localparam int CW = $clog2(MAX_SYMBOLS + 1);
	localparam int KW = $clog2(MAX_SYMBOLS + 2);
	localparam int STW = 5;

	localparam logic [STW-1:0] S_LOAD = 5'd0;
	localparam logic [STW-1:0] S_INIT = 5'd1;
	localparam logic [STW-1:0] S_HSTART = 5'd2;
	localparam logic [STW-1:0] S_SD_A = 5'd3;
	localparam logic [STW-1:0] S_SD_B = 5'd4;
	localparam logic [STW-1:0] S_SD_C = 5'd5;
	localparam logic [STW-1:0] S_SD_D = 5'd6;
	localparam logic [STW-1:0] S_SD_E = 5'd7;
	localparam logic [STW-1:0] S_SD_F = 5'd8;
	localparam logic [STW-1:0] S_SD_G = 5'd9;
	localparam logic [STW-1:0] S_SD_H = 5'd10;
	localparam logic [STW-1:0] S_SD_I = 5'd11;
	localparam logic [STW-1:0] S_MERGE = 5'd12;
	localparam logic [STW-1:0] S_TK_A = 5'd13;
	localparam logic [STW-1:0] S_TK_B = 5'd14;
	localparam logic [STW-1:0] S_TK_C = 5'd15;
	localparam logic [STW-1:0] S_SUM_A = 5'd16;
	localparam logic [STW-1:0] S_SUM_B = 5'd17;
	localparam logic [STW-1:0] S_SU_A = 5'd18;
	localparam logic [STW-1:0] S_SU_B = 5'd19;
	localparam logic [STW-1:0] S_SU_C = 5'd20;
	localparam logic [STW-1:0] S_ROOT_A = 5'd21;
	localparam logic [STW-1:0] S_ROOT_B = 5'd22;
	localparam logic [STW-1:0] S_W_POP = 5'd23;
	localparam logic [STW-1:0] S_W_A = 5'd24;
	localparam logic [STW-1:0] S_W_B = 5'd25;
	localparam logic [STW-1:0] S_W_C = 5'd26;
	localparam logic [STW-1:0] S_W_OUT = 5'd27;
	localparam logic [STW-1:0] S_W_PUSH = 5'd28;
	localparam logic [STW-1:0] S_SUM_C = 5'd29;

	logic [STW-1:0] state_q;
	logic [CW-1:0] count_q, size_q;
	logic overflow_q;
	logic [NW-1:0] next_q;
	logic [SW:0] at_q, best_q, cidx_q, i_q;
	logic [NW-1:0] at_node_q, best_node_q, cand_node_q, node_a_q, node_b_q, node_q, ins_node_q;
	logic [WEIGHT_W-1:0] best_w_q, ins_w_q, sum_w;
	logic second_q, child_r_q;
	logic [KW-1:0] sp_q;
	logic [CODE_W-1:0] code_q;
	logic [LEN_W:0] len_q;
	logic out_valid_q;
	hctb_out_t out_q;
	logic [SW:0] hstart_q;
	logic sift_mode_q;

	// Weights.
	logic w_we;
	logic [NW-1:0] w_wa, w_ra;
	logic [WEIGHT_W-1:0] w_wd, w_rd;
	hctb_ram #(.WIDTH(WEIGHT_W), .DEPTH(NODES)) u_weight (
		.clk(clk), .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(w_ra), .rdata(w_rd));

	logic k_we;
	logic [NW-1:0] k_wa, k_ra;
	logic [2*NW-1:0] k_wd, k_rd;
	hctb_ram #(.WIDTH(2 * NW), .DEPTH(NODES)) u_kids (
		.clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));

	logic s_we;
	logic [SW-1:0] s_wa, s_ra;
	logic [23:0] s_wd, s_rd;
	hctb_ram #(.WIDTH(24), .DEPTH(MAX_SYMBOLS)) u_sym (
		.clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

	logic h_we;
	logic [SW-1:0] h_wa, h_ra;
	logic [NW-1:0] h_wd, h_rd;
	hctb_ram #(.WIDTH(NW), .DEPTH(MAX_SYMBOLS)) u_heap (
		.clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));

	logic t_we;
	logic [KW-1:0] t_wa, t_ra;
	logic [NW+CODE_W+LEN_W:0] t_wd, t_rd;
	hctb_ram #(.WIDTH(NW + CODE_W + LEN_W + 1), .DEPTH(MAX_SYMBOLS + 1)) u_stack (
		.clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));

	logic accept;
	logic [SW:0] parent;
	logic [CODE_W-1:0] ncode;
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_LOAD);
	assign out_valid = out_valid_q;
	assign out_data = out_q;
	assign parent = (i_q - 1'b1) >> 1;
	assign ncode = {code_q[CODE_W-2:0], 1'b0};
	assign sum_w = WEIGHT_W'(best_w_q + w_rd);

	always_comb begin
		w_we = 1'b0;
		w_wa = next_q;
		w_wd = sum_w;
		w_ra = best_node_q;
		k_we = 1'b0;
		k_wa = next_q;
		k_wd = {node_a_q, node_b_q};
		k_ra = node_q;
		s_we = 1'b0;
		s_wa = count_q[SW-1:0];
		s_wd = in_data.symbol_rgb;
		s_ra = node_q[SW-1:0];
		h_we = 1'b0;
		h_wa = i_q[SW-1:0];
		h_wd = i_q[NW-1:0];
		h_ra = cidx_q[SW-1:0];
		t_we = 1'b0;
		t_wa = sp_q;
		t_wd = '0;
		t_ra = sp_q;
		unique case (state_q)
			S_LOAD: begin
				if (accept && (count_q < CW'(MAX_SYMBOLS))) begin
					s_we = 1'b1;
					w_we = 1'b1;
					w_wa = NW'(count_q);
					w_wd = WEIGHT_W'(in_data.symbol_weight);
				end
			end
			S_INIT: h_we = 1'b1;
			S_SD_A: h_ra = at_q[SW-1:0];
			S_SD_B: w_ra = h_rd;
			S_SD_D, S_SD_F: w_ra = h_rd;
			S_SD_E: h_ra = SW'(cidx_q + 1'b1);
			S_SD_H: begin
				h_we = 1'b1;
				h_wa = best_q[SW-1:0];
				h_wd = at_node_q;
			end
			S_SD_I: begin
				h_we = 1'b1;
				h_wa = at_q[SW-1:0];
				h_wd = best_node_q;
			end
			S_TK_A: h_ra = '0;
			S_TK_B: h_ra = SW'(size_q - 1'b1);
			S_TK_C: begin
				h_we = 1'b1;
				h_wa = '0;
				h_wd = h_rd;
			end
			S_SUM_A: w_ra = node_a_q;
			S_SUM_B: w_ra = node_b_q;
			S_SUM_C: begin
				w_we = 1'b1;
				k_we = 1'b1;
			end
			S_SU_A: h_ra = parent[SW-1:0];
			S_SU_B: w_ra = h_rd;
			S_SU_C: begin
				h_we = 1'b1;
				if ((i_q != 0) && (ins_w_q < w_rd)) begin
					h_wd = cand_node_q;
				end else begin
					h_wd = ins_node_q;
				end
			end
			S_ROOT_A: h_ra = '0;
			S_ROOT_B: begin
				t_we = 1'b1;
				t_wa = '0;
				t_wd = {h_rd, {CODE_W{1'b0}}, {(LEN_W + 1){1'b0}}};
			end
			S_W_POP: t_ra = sp_q - 1'b1;
			S_W_B: k_ra = node_q;
			S_W_PUSH: begin
				t_we = 1'b1;
				if (!child_r_q) begin
					t_wd = {k_rd[NW-1:0], ncode | CODE_W'(1), len_q + 1'b1};
				end else begin
					t_wd = {k_rd[2*NW-1:NW], ncode, len_q + 1'b1};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			count_q <= '0;
			overflow_q <= 1'b0;
			out_valid_q <= 1'b0;
			size_q <= '0;
			next_q <= '0;
			sp_q <= '0;
			sift_mode_q <= 1'b0;
			second_q <= 1'b0;
			child_r_q <= 1'b0;
			i_q <= '0;
			hstart_q <= '0;
		end else begin
			if ((state_q == S_W_OUT) && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (count_q < CW'(MAX_SYMBOLS)) begin
							count_q <= count_q + 1'b1;
						end else begin
							overflow_q <= 1'b1;
						end
						if (in_data.last_symbol) begin
							state_q <= S_INIT;
							i_q <= '0;
						end
					end
				end
				S_INIT: begin
					if (i_q + 1'b1 >= (SW + 1)'(count_q)) begin
						size_q <= count_q;
						next_q <= NW'(count_q);
						hstart_q <= (SW + 1)'(count_q >> 1) + 1'b1;
						sift_mode_q <= 1'b0;
						state_q <= S_HSTART;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_HSTART: begin
					if (hstart_q == 0) begin
						state_q <= S_MERGE;
					end else begin
						at_q <= hstart_q - 1'b1;
						hstart_q <= hstart_q - 1'b1;
						state_q <= S_SD_A;
					end
				end
				S_SD_A: state_q <= S_SD_B;
				S_SD_B: begin
					at_node_q <= h_rd;
					best_node_q <= h_rd;
					best_q <= at_q;
					cidx_q <= (at_q << 1) + 1'b1;
					state_q <= S_SD_C;
				end
				S_SD_C: begin
					best_w_q <= w_rd;
					if (cidx_q < (SW + 1)'(size_q)) begin
						state_q <= S_SD_D;
					end else begin
						state_q <= S_SD_G;
					end
				end
				S_SD_D: begin
					cand_node_q <= h_rd;
					state_q <= S_SD_E;
				end
				S_SD_E: begin
					if (w_rd < best_w_q) begin
						best_w_q <= w_rd;
						best_q <= cidx_q;
						best_node_q <= cand_node_q;
					end
					cidx_q <= cidx_q + 1'b1;
					if (cidx_q[0] && (cidx_q + 1'b1 < (SW + 1)'(size_q))) begin
						state_q <= S_SD_D;
					end else begin
						state_q <= S_SD_G;
					end
				end
				S_SD_G: begin
					if (best_q == at_q) begin
						state_q <= sift_mode_q ? (second_q ? S_SUM_A : S_TK_A) : S_HSTART;
						if (sift_mode_q) second_q <= 1'b1;
					end else begin
						state_q <= S_SD_H;
					end
				end
				S_SD_H: state_q <= S_SD_I;
				S_SD_I: begin
					at_q <= best_q;
					state_q <= S_SD_A;
				end
				S_MERGE: begin
					sift_mode_q <= 1'b1;
					second_q <= 1'b0;
					if (size_q > 1) begin
						state_q <= S_TK_A;
					end else begin
						state_q <= S_ROOT_A;
					end
				end
				S_TK_A: state_q <= S_TK_B;
				S_TK_B: begin
					if (second_q) begin
						node_b_q <= h_rd;
					end else begin
						node_a_q <= h_rd;
					end
					state_q <= S_TK_C;
				end
				S_TK_C: begin
					size_q <= size_q - 1'b1;
					at_q <= '0;
					state_q <= S_SD_A;
				end
				S_SUM_A: state_q <= S_SUM_B;
				S_SUM_B: begin
					best_w_q <= w_rd;
					state_q <= S_SUM_C;
				end
				S_SUM_C: begin
					ins_w_q <= sum_w;
					ins_node_q <= next_q;
					i_q <= (SW + 1)'(size_q);
					size_q <= size_q + 1'b1;
					state_q <= S_SU_A;
				end
				S_SU_A: state_q <= S_SU_B;
				S_SU_B: begin
					cand_node_q <= h_rd;
					state_q <= S_SU_C;
				end
				S_SU_C: begin
					if ((i_q != 0) && (ins_w_q < w_rd)) begin
						i_q <= parent;
						state_q <= S_SU_A;
					end else begin
						next_q <= next_q + 1'b1;
						state_q <= S_MERGE;
					end
				end
				S_ROOT_A: state_q <= S_ROOT_B;
				S_ROOT_B: begin
					sp_q <= KW'(1);
					state_q <= S_W_POP;
				end
				S_W_POP: begin
					if (sp_q == 0) begin
						count_q <= '0;
						overflow_q <= 1'b0;
						state_q <= S_LOAD;
					end else begin
						sp_q <= sp_q - 1'b1;
						state_q <= S_W_A;
					end
				end
				S_W_A: begin
					node_q <= t_rd[NW+CODE_W+LEN_W:CODE_W+LEN_W+1];
					code_q <= t_rd[CODE_W+LEN_W:LEN_W+1];
					len_q <= t_rd[LEN_W:0];
					state_q <= S_W_B;
				end
				S_W_B: state_q <= S_W_C;
				S_W_C: begin
					if (node_q < NW'(count_q)) begin
						state_q <= S_W_OUT;
					end else if ((sp_q + 2'd2 <= KW'(MAX_SYMBOLS + 1))
						&& (len_q < (LEN_W + 1)'(CODE_W))) begin
						child_r_q <= 1'b0;
						state_q <= S_W_PUSH;
					end else begin
						state_q <= S_W_POP;
					end
				end
				S_W_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_q.leaf_symbol <= s_rd;
						out_q.code_bits <= code_q;
						out_q.code_length <= len_q[LEN_W-1:0];
						out_q.table_full <= overflow_q;
						out_q.final_code <= (sp_q == 0);
						state_q <= S_W_POP;
					end
				end
				S_W_PUSH: begin
					sp_q <= sp_q + 1'b1;
					if (child_r_q) begin
						state_q <= S_W_POP;
					end else begin
						child_r_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	`include "huffman_code_table_builder_assert.svh"

	`HCTB_ASSERT_IMPL(a_stall_busy, (state_q != S_LOAD), in_stall)
	`HCTB_ASSERT_IMPL(a_count_cap, 1'b1, (count_q <= CW'(MAX_SYMBOLS)))
	`HCTB_ASSERT_NEXT(a_out_hold, (out_valid && out_stall), (out_valid && $stable(out_data)))
endmodule

FILE: design/hctb_ram.sv
module hctb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: verif/huffman_code_table_checker.sv
`timescale 1ns / 100ps
module huffman_code_table_checker
	import hctb_pkg::*;
#(
	parameter int MAX_SYMBOLS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  hctb_in_t  in_data,
	input  logic      out_valid,
	input  logic      out_stall,
	input  hctb_out_t out_data,
	output int        fail_count,
	output int        codes_pending
);
	localparam int NODE_CAP = 2 * MAX_SYMBOLS - 1;

	logic [23:0] sym_store [MAX_SYMBOLS];
	logic [30:0] weight [NODE_CAP];
	int          left_of [NODE_CAP];
	int          right_of [NODE_CAP];
	int          heap [MAX_SYMBOLS];
	int          n_loaded;
	logic        dropped;
	hctb_out_t   code_queue [$];

	assign codes_pending = code_queue.size();

	function automatic void sift_down(int size, int at);
		int best;
		int t;
		forever begin
			best = at;
			if (2 * at + 1 < size && weight[heap[2 * at + 1]] < weight[heap[best]])
				best = 2 * at + 1;
			if (2 * at + 2 < size && weight[heap[2 * at + 2]] < weight[heap[best]])
				best = 2 * at + 2;
			if (best == at)
				return;
			t = heap[best];
			heap[best] = heap[at];
			heap[at] = t;
			at = best;
		end
	endfunction

	function automatic int pop_min(ref int size);
		int top;
		top = heap[0];
		heap[0] = heap[size - 1];
		size--;
		sift_down(size, 0);
		return top;
	endfunction

	function automatic void build_codes();
		int size;
		int nxt;
		int a;
		int b;
		int i;
		int sp;
		int node;
		int stk [MAX_SYMBOLS + 1];
		logic [62:0] cstk [MAX_SYMBOLS + 1];
		int lstk [MAX_SYMBOLS + 1];
		logic [62:0] code;
		int len;
		int first_new;
		hctb_out_t r;
		first_new = code_queue.size();
		for (i = 0; i < n_loaded; i++)
			heap[i] = i;
		for (i = n_loaded / 2; i >= 0; i--)
			sift_down(n_loaded, i);
		size = n_loaded;
		nxt = n_loaded;
		while (size > 1) begin
			a = pop_min(size);
			b = pop_min(size);
			weight[nxt] = weight[a] + weight[b];
			left_of[nxt] = a;
			right_of[nxt] = b;
			i = size;
			size++;
			while (i != 0 && weight[nxt] < weight[heap[(i - 1) / 2]]) begin
				heap[i] = heap[(i - 1) / 2];
				i = (i - 1) / 2;
			end
			heap[i] = nxt;
			nxt++;
		end
		stk[0] = heap[0];
		cstk[0] = '0;
		lstk[0] = 0;
		sp = 1;
		while (sp > 0) begin
			sp--;
			node = stk[sp];
			code = cstk[sp];
			len = lstk[sp];
			if (node < n_loaded) begin
				r.leaf_symbol = sym_store[node];
				r.code_bits = code;
				r.code_length = len[5:0];
				r.table_full = dropped;
				r.final_code = 1'b0;
				code_queue.push_back(r);
			end else if (sp + 2 <= MAX_SYMBOLS + 1 && len < 63) begin
				stk[sp] = right_of[node];
				cstk[sp] = {code[61:0], 1'b1};
				lstk[sp] = len + 1;
				sp++;
				stk[sp] = left_of[node];
				cstk[sp] = {code[61:0], 1'b0};
				lstk[sp] = len + 1;
				sp++;
			end
		end
		if (code_queue.size() > first_new)
			code_queue[code_queue.size() - 1].final_code = 1'b1;
		n_loaded = 0;
		dropped = 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hctb_out_t exp_code;
		if (!arst_n) begin
			n_loaded = 0;
			dropped = 1'b0;
			fail_count = 0;
			code_queue.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (code_queue.size() == 0) begin
					$display("%0t: unexpected code, actual %p", $time, out_data);
					fail_count++;
				end else begin
					exp_code = code_queue.pop_front();
					if (out_data !== exp_code) begin
						$display("%0t: code mismatch, expected %p, actual %p",
							$time, exp_code, out_data);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (n_loaded < MAX_SYMBOLS) begin
					sym_store[n_loaded] = in_data.symbol_rgb;
					weight[n_loaded] = {7'd0, in_data.symbol_weight};
					n_loaded++;
				end else begin
					dropped = 1'b1;
				end
				if (in_data.last_symbol)
					build_codes();
			end
		end
	end
endmodule

FILE: verif/huffman_code_table_builder_tb.sv
`timescale 1ns / 100ps
module huffman_code_table_builder_tb;
	import hctb_pkg::*;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	hctb_in_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	hctb_out_t out_data;
	int        fail_count;
	int        codes_pending;
	int        idle_cycles = 0;
	logic      calm = 1'b0;

	always #5 clk = ~clk;

	huffman_code_table_builder i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	huffman_code_table_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.fail_count(fail_count), .codes_pending(codes_pending)
	);

	always @(posedge clk) begin
		if (arst_n)
			out_stall <= !calm && ($urandom_range(99) < 21);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 200000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_symbol(input logic [23:0] rgb, input logic [23:0] w,
			input logic last);
		while (!calm && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{symbol_rgb: rgb, symbol_weight: w, last_symbol: last};
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (codes_pending != 0)
			@(posedge clk);
	endtask

	task automatic send_set(input int count, input int wmode);
		logic [23:0] w;
		for (int i = 0; i < count; i++) begin
			case (wmode)
				0: w = 24'($urandom_range(16));
				1: w = 24'($urandom);
				2: w = 24'hFFFFFF;
				default: w = 24'd1 << (i % 24);
			endcase
			if (wmode != 0 && w == 0)
				w = 1;
			send_symbol(24'($urandom), w, i == count - 1);
		end
	endtask

	initial begin
		int sent;
		int cnt;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_symbol(24'hFFFFFF, 24'hFFFFFF, 1'b1);
		send_symbol(24'h000000, 24'd1, 1'b0);
		send_symbol(24'hABCDEF, 24'hFFFFFF, 1'b1);
		send_symbol(24'h123456, 24'd0, 1'b0);
		send_symbol(24'h654321, 24'd5, 1'b0);
		send_symbol(24'h111111, 24'd5, 1'b1);
		for (int i = 0; i < 4; i++)
			send_symbol(24'(256 + i), 24'd7, i == 3);
		send_set(5, 3);
		drain();
		repeat (20) @(posedge clk);
		sent = 15;
		send_set(64, 2);
		send_set(66, 3);
		sent += 130;
		calm <= 1'b1;
		send_set(40, 1);
		drain();
		calm <= 1'b0;
		sent += 40;
		while (sent < 460) begin
			cnt = ($urandom_range(9) == 0) ? $urandom_range(2, 66) : $urandom_range(1, 12);
			if (cnt > 460 - sent)
				cnt = 460 - sent;
			send_set(cnt, $urandom_range(3));
			sent += cnt;
		end
		drain();
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

FILE: files.f
+incdir+design
design/hctb_pkg.sv
design/hctb_ram.sv
design/huffman_code_table_builder.sv
verif/huffman_code_table_checker.sv
verif/huffman_code_table_builder_tb.sv
